/* rtl/f2h_pkg.sv */
package f2h_pkg;

  typedef struct packed {
    logic [31:0] single_word;
    logic        last_element;
  } f2h_in_t;

  typedef struct packed {
    logic [15:0] half_word;
    logic        last_out;
  } f2h_out_t;

  // operand class decoded in the first stage
  typedef enum logic [1:0] {
    CLS_ZERO   = 2'd0,
    CLS_INF    = 2'd1,
    CLS_NAN    = 2'd2,
    CLS_FINITE = 2'd3
  } f2h_cls_e;

  // first stage result: classified operand with the shift amount prepared
  typedef struct packed {
    logic        sign;
    f2h_cls_e    cls;
    logic        normal;     // lands in the binary16 normal range
    logic [4:0]  hexp;       // biased binary16 exponent when normal
    logic [4:0]  shift;      // right shift for the subnormal path (14..24)
    logic [23:0] sig;        // significand with hidden bit
    logic        last;
  } f2h_dec_t;

  // second stage result: truncated body plus rounding information
  typedef struct packed {
    logic        sign;
    f2h_cls_e    cls;
    logic [14:0] body;
    logic        round_up;
    logic [9:0]  nan_pay;
    logic        last;
  } f2h_rnd_t;

  localparam logic [14:0] HalfInf = 15'h7C00;
  localparam logic [14:0] HalfQnan = 15'h7E00;

endpackage

/* rtl/f2h_decode.sv */
module f2h_decode
  import f2h_pkg::*;
(
  input  f2h_in_t    in_i,
  output f2h_dec_t   dec_o
);

  logic [7:0] exp;
  logic [4:0] hexp_s;

  assign exp = in_i.single_word[30:23];
  // binary16 biased exponent: exp - 112
  assign hexp_s = 5'(exp - 8'd112);

  // classify the operand and prepare the shift
  always_comb begin
    dec_o.sign   = in_i.single_word[31];
    dec_o.sig    = {1'b1, in_i.single_word[22:0]};
    dec_o.last   = in_i.last_element;
    dec_o.hexp   = hexp_s;
    dec_o.normal = 1'b0;
    dec_o.shift  = 5'd0;
    if (exp == 8'hFF) begin
      dec_o.cls = (in_i.single_word[22:0] == 23'd0) ? CLS_INF : CLS_NAN;
    end else if (exp == 8'd0) begin
      dec_o.cls = CLS_ZERO;
    end else if (exp >= 8'd143) begin
      dec_o.cls = CLS_INF;
    end else if (exp >= 8'd113) begin
      dec_o.cls    = CLS_FINITE;
      dec_o.normal = 1'b1;
    end else if (exp < 8'd102) begin
      // shift beyond 24 leaves nothing
      dec_o.cls = CLS_ZERO;
    end else begin
      dec_o.cls   = CLS_FINITE;
      dec_o.shift = 5'(8'd126 - exp);
    end
  end

endmodule

/* rtl/f2h_round.sv */
module f2h_round
  import f2h_pkg::*;
(
  input  f2h_dec_t dec_i,
  output f2h_rnd_t rnd_o
);

  logic [47:0] ext;
  logic [23:0] q;
  logic [23:0] rem;
  logic [23:0] half;
  logic [12:0] nrem;

  // align the significand for the subnormal path
  assign ext  = {dec_i.sig, 24'd0} >> dec_i.shift;
  assign q    = ext[47:24];
  assign rem  = ext[23:0];
  assign half = 24'h800000;
  assign nrem = dec_i.sig[12:0];

  // build the truncated body and the round-up decision
  always_comb begin
    rnd_o.sign    = dec_i.sign;
    rnd_o.cls     = dec_i.cls;
    rnd_o.last    = dec_i.last;
    rnd_o.nan_pay = dec_i.sig[22:13];
    if (dec_i.normal) begin
      rnd_o.body     = {dec_i.hexp, dec_i.sig[22:13]};
      rnd_o.round_up = (nrem > 13'h1000) || (nrem == 13'h1000 && dec_i.sig[13]);
    end else begin
      rnd_o.body     = q[14:0];
      rnd_o.round_up = (rem > half) || (rem == half && q[0]);
    end
  end

endmodule

/* rtl/fp32_to_fp16_converter_top.sv */
// binary32 to binary16 converter, round to nearest even.
//
// Input channel: present a beat on in_i with start high; it is taken at
// the rising edge where start is high and busy is low. busy is tied
// low, so a beat may enter on every cycle.
// Output channel: each result appears on out_o for exactly one cycle with
// done_o high, and is taken at the edge that ends that cycle. The receiver
// cannot stall.
// Path: an accepted beat passes the decode register, round register and
// output register before done_o is high. Throughput: one beat per cycle,
// set by the three-stage pipeline.
// Reset (rst_ni low, asynchronous) clears all valid bits; beats in flight
// are dropped and done_o stays low until new beats arrive.
// The last_element flag travels with its beat to last_out.
module fp32_to_fp16_converter_top
  import f2h_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  f2h_in_t  in_i,
  output logic     busy,
  output logic     done_o,
  output f2h_out_t out_o
);

  f2h_dec_t dec_d, dec_q;
  f2h_rnd_t rnd_d, rnd_q;
  f2h_out_t out_d, out_q;
  logic     v1_q, v2_q, v3_q;
  logic     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  f2h_decode u_decode (.in_i(in_i), .dec_o(dec_d));
  f2h_round  u_round  (.dec_i(dec_q), .rnd_o(rnd_d));

  // apply rounding and special encodings
  always_comb begin
    out_d.last_out = rnd_q.last;
    unique case (rnd_q.cls)
      CLS_ZERO:   out_d.half_word = {rnd_q.sign, 15'd0};
      CLS_INF:    out_d.half_word = {rnd_q.sign, HalfInf};
      CLS_NAN:    out_d.half_word = {rnd_q.sign, HalfQnan | {5'd0, rnd_q.nan_pay}};
      CLS_FINITE: out_d.half_word = {rnd_q.sign, rnd_q.body + {14'd0, rnd_q.round_up}};
      default:    out_d.half_word = 16'd0;
    endcase
  end

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
    rnd_q <= rnd_d;
    out_q <= out_d;
  end

  assign done_o = v3_q;
  assign out_o  = out_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##2 done_o) else $error("beat lost in pipeline");
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 3)) else $error("result without input beat");
  a_last_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_o.last_out == $past(in_i.last_element, 3))
    else $error("last flag mismatch");

endmodule
